@@ sv/a64mct_pkg.sv @@
package a64mct_pkg;

  localparam int WORD_W     = 32;
  localparam int VAL_W      = 64;
  localparam int STATUS_W   = 3;
  localparam int NREGS      = 32;
  localparam int REG_W      = 5;
  localparam int WINDOW_DEF = 16;

  localparam logic [WORD_W-1:0] MW_OP_MASK  = 32'h7F80_0000;
  localparam logic [WORD_W-1:0] OP_MOVN     = 32'h1280_0000;
  localparam logic [WORD_W-1:0] OP_MOVZ     = 32'h5280_0000;
  localparam logic [WORD_W-1:0] OP_MOVK     = 32'h7280_0000;
  localparam logic [WORD_W-1:0] RMOV_MASK   = 32'h7FE0_FFE0;
  localparam logic [WORD_W-1:0] RMOV_CODE   = 32'h2A00_03E0;
  localparam logic [WORD_W-1:0] PACGA_MASK  = 32'hFFE0_FC00;
  localparam logic [WORD_W-1:0] PACGA_CODE  = 32'h9AC0_3000;
  localparam logic [WORD_W-1:0] NOP_CODE    = 32'hD503_201F;
  localparam logic [15:0]       LANE_ONES   = 16'hFFFF;
  localparam logic [VAL_W-1:0]  LOW32_MASK  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [REG_W-1:0]  REG_ZR      = 5'd31;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_PACGA = 3'd1,
    ST_REG31     = 3'd2,
    ST_NO_RUN    = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HIST,
    S_DEC,
    S_APPLY,
    S_RDN,
    S_RDM,
    S_OUT
  } state_t;

  function automatic logic is_move_wide(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] op;
    op = w & MW_OP_MASK;
    return (op == OP_MOVN) || (op == OP_MOVZ) || (op == OP_MOVK);
  endfunction

  function automatic logic is_reg_move(input logic [WORD_W-1:0] w);
    return (w & RMOV_MASK) == RMOV_CODE;
  endfunction

  function automatic logic is_block_word(input logic [WORD_W-1:0] w);
    return is_move_wide(w) || is_reg_move(w) || (w == NOP_CODE);
  endfunction

endpackage

@@ sv/a64mct_if.sv @@
interface a64mct_in_if;
  logic                              valid;
  logic                              ready;
  logic [a64mct_pkg::WORD_W-1:0]     instruction_word;
  logic                              resolve_here;

  modport source (output valid, output instruction_word, output resolve_here, input ready);
  modport sink   (input valid, input instruction_word, input resolve_here, output ready);
endinterface

interface a64mct_out_if;
  logic                              valid;
  logic                              ready;
  logic [a64mct_pkg::STATUS_W-1:0]   status;
  logic [a64mct_pkg::VAL_W-1:0]      data_value;
  logic [a64mct_pkg::VAL_W-1:0]      modifier_value;

  modport source (output valid, output status, output data_value, output modifier_value,
                  input ready);
  modport sink   (input valid, input status, input data_value, input modifier_value,
                  output ready);
endinterface

@@ sv/a64mct_ram.sv @@
module a64mct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/a64_move_constant_tracker.sv @@
// Channel   Dir  Fields                                     Beat when
// in_ch     in   instruction_word[31:0], resolve_here       valid && ready
// out_ch    out  status[2:0], data_value[63:0],             valid && ready
//                modifier_value[63:0]
//
// A word without resolve_here is taken in idle, and the block stays in idle; in_ch.ready is high in idle.
// A resolve word that fails an early check goes straight to S_OUT; otherwise each
// run entry is replayed through S_HIST, S_DEC and S_APPLY: a history RAM read, a
// constant RAM read and a conditional constant RAM write, then S_RDN, S_RDM, S_OUT.
// Reset (rst_n low, synchronous) empties the run and clears all known flags.
// A held result stalls only the finish of the next resolve, not plain words.
module a64_move_constant_tracker #(
  parameter int WINDOW = a64mct_pkg::WINDOW_DEF
) (
  input  logic clk,
  input  logic rst_n,
  a64mct_in_if.sink    in_ch,
  a64mct_out_if.source out_ch
);
  import a64mct_pkg::*;

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LW = $clog2(WINDOW + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW - 1);
  localparam logic [LW-1:0] WIN_LEN  = LW'(WINDOW);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [LW-1:0]     cnt_r, cnt_nxt;
  logic [NREGS-1:0]  known_r, known_nxt;
  logic [WORD_W-1:0] pend_r, pend_nxt;
  logic [WORD_W-1:0] h_r, h_nxt;
  status_t           st_r, st_nxt;
  logic [VAL_W-1:0]  dval_r, dval_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_data_r, out_data_nxt;
  logic [VAL_W-1:0]  out_mod_r, out_mod_nxt;

  logic              hist_we;
  logic [WORD_W-1:0] hist_wdata, hist_rdata;
  logic              cv_we;
  logic [REG_W-1:0]  cv_waddr, cv_raddr;
  logic [VAL_W-1:0]  cv_wdata, cv_rdata;

  logic              push_en;
  logic [WORD_W-1:0] push_word;
  logic              in_beat, out_free;

  logic [REG_W-1:0]  pn, pm, hd, hs, dd;
  logic [1:0]        lane;
  logic              wide;
  logic [VAL_W-1:0]  imm, lmask, wmask;
  logic [WORD_W-1:0] in_w;

  a64mct_ram #(.WIDTH(WORD_W), .DEPTH(WINDOW)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (tail_r),
    .wdata (hist_wdata),
    .raddr (rptr_r),
    .rdata (hist_rdata)
  );

  a64mct_ram #(.WIDTH(VAL_W), .DEPTH(NREGS)) u_cval (
    .clk   (clk),
    .we    (cv_we),
    .waddr (cv_waddr),
    .wdata (cv_wdata),
    .raddr (cv_raddr),
    .rdata (cv_rdata)
  );

  assign in_w     = in_ch.instruction_word;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign pn   = pend_r[9:5];
  assign pm   = pend_r[20:16];
  assign hd   = h_r[4:0];
  assign hs   = h_r[20:16];
  assign dd   = hist_rdata[4:0];
  assign lane = h_r[22:21];
  assign wide = h_r[31];
  assign imm   = {48'b0, h_r[20:5]} << {lane, 4'b0};
  assign lmask = {48'b0, LANE_ONES} << {lane, 4'b0};
  assign wmask = wide ? '1 : LOW32_MASK;

  always_comb begin
    state_nxt      = state_r;
    rptr_nxt       = rptr_r;
    cnt_nxt        = cnt_r;
    known_nxt      = known_r;
    pend_nxt       = pend_r;
    h_nxt          = h_r;
    st_nxt         = st_r;
    dval_nxt       = dval_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_mod_nxt    = out_mod_r;
    push_en        = 1'b0;
    push_word      = in_w;
    cv_we          = 1'b0;
    cv_waddr       = hd;
    cv_wdata       = '0;
    cv_raddr       = pm;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (in_ch.resolve_here) begin
            pend_nxt = in_w;
            rptr_nxt = head_r;
            cnt_nxt  = len_r;
            st_nxt   = ST_OK;
            if ((in_w & PACGA_MASK) != PACGA_CODE) begin
              st_nxt    = ST_NOT_PACGA;
              state_nxt = S_OUT;
            end else if (in_w[9:5] == REG_ZR || in_w[20:16] == REG_ZR) begin
              st_nxt    = ST_REG31;
              state_nxt = S_OUT;
            end else if (len_r == '0) begin
              st_nxt    = ST_NO_RUN;
              state_nxt = S_OUT;
            end else begin
              known_nxt = '0;
              state_nxt = S_HIST;
            end
          end else begin
            push_en = 1'b1;
          end
        end
      end
      S_HIST: begin
        rptr_nxt  = wrap_inc(rptr_r);
        state_nxt = S_DEC;
      end
      S_DEC: begin
        h_nxt     = hist_rdata;
        cv_raddr  = is_reg_move(hist_rdata) ? hist_rdata[20:16] : dd;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (is_move_wide(h_r)) begin
          if (!wide && lane[1]) begin
            known_nxt[hd] = 1'b0;
          end else if ((h_r & MW_OP_MASK) == OP_MOVZ) begin
            cv_we         = 1'b1;
            cv_wdata      = imm & wmask;
            known_nxt[hd] = 1'b1;
          end else if ((h_r & MW_OP_MASK) == OP_MOVN) begin
            cv_we         = 1'b1;
            cv_wdata      = ~imm & wmask;
            known_nxt[hd] = 1'b1;
          end else if (known_r[hd]) begin
            cv_we    = 1'b1;
            cv_wdata = ((cv_rdata & ~lmask) | imm) & wmask;
          end
        end else if (is_reg_move(h_r) && hd != REG_ZR) begin
          cv_we = 1'b1;
          if (hs == REG_ZR) begin
            cv_wdata      = '0;
            known_nxt[hd] = 1'b1;
          end else begin
            cv_wdata      = cv_rdata & wmask;
            known_nxt[hd] = known_r[hs];
          end
        end
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = (cnt_r == LW'(1)) ? S_RDN : S_HIST;
      end
      S_RDN: begin
        cv_raddr  = pn;
        state_nxt = S_RDM;
      end
      S_RDM: begin
        dval_nxt  = cv_rdata;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_mod_nxt   = '0;
          if (st_r != ST_OK) begin
            out_status_nxt = st_r;
          end else if (!known_r[pn] || !known_r[pm]) begin
            out_status_nxt = ST_UNKNOWN;
          end else begin
            out_status_nxt = ST_OK;
            out_data_nxt   = dval_r;
            out_mod_nxt    = cv_rdata;
          end
          push_en   = 1'b1;
          push_word = pend_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // advance the run ring; drop the oldest when full, empty on a non-block word
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    len_nxt    = len_r;
    hist_we    = 1'b0;
    hist_wdata = push_word;
    if (push_en) begin
      if (!is_block_word(push_word)) begin
        len_nxt  = '0;
        head_nxt = tail_r;
      end else begin
        hist_we  = 1'b1;
        tail_nxt = wrap_inc(tail_r);
        if (len_r == WIN_LEN) begin
          head_nxt = wrap_inc(head_r);
        end else begin
          len_nxt = len_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      rptr_r      <= '0;
      cnt_r       <= '0;
      known_r     <= '0;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      rptr_r      <= rptr_nxt;
      cnt_r       <= cnt_nxt;
      known_r     <= known_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r       <= pend_nxt;
    h_r          <= h_nxt;
    dval_r       <= dval_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_mod_r    <= out_mod_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.data_value     = out_data_r;
  assign out_ch.modifier_value = out_mod_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= WIN_LEN)
    else $error("run length beyond window");

  a_replay_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HIST && $past(state_r) == S_IDLE) |-> (cnt_r != '0))
    else $error("replay entered with empty run");

  a_ok_known: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free && st_r == ST_OK && out_status_nxt == ST_OK)
      |-> (known_r[pn] && known_r[pm]))
    else $error("resolved with unknown operand");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_data_r == '0 && out_mod_r == '0))
    else $error("nonzero operands on failed resolve");

  a_busy_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HIST || state_r == S_DEC || state_r == S_APPLY) |-> !hist_we)
    else $error("run changed during replay");

endmodule
